// ----- sv/m2mp_pkg.sv -----
package m2mp_pkg;

	localparam int unsigned ENTRY_W = 30;
	localparam int unsigned PROD_W  = 60;
	localparam logic [29:0] PRIME   = 30'd1000000007;

	// register stages through one matrix product
	localparam int unsigned MUL_LAT = 6;

	// floor(2^60 / PRIME), 31 bits, for the reciprocal estimate of a 60-bit value
	localparam logic [30:0] RECIP = 31'd1152921496;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		entry_t m00;
		entry_t m01;
		entry_t m10;
		entry_t m11;
	} mat_t;

	localparam mat_t MAT_IDENT = '{m00: 30'd1, m01: 30'd0, m10: 30'd0, m11: 30'd1};

	// one conditional subtraction brings a value below twice the prime under it
	function automatic entry_t fold_once(input logic [ENTRY_W:0] v);
		logic [ENTRY_W:0] d;
		d = v - {1'b0, PRIME};
		fold_once = d[ENTRY_W] ? v[ENTRY_W-1:0] : d[ENTRY_W-1:0];
	endfunction

endpackage

// ----- sv/matrix2x2_modular_power.sv -----
// Channel | Direction | Signals                                   | Handshake
// in      | in        | entry_00..entry_11, exponent              | start & !busy
// out     | out       | result_00..result_11                      | done, one cycle
//
// One beat may enter every cycle; busy stays low. The path holds
// one input reduce stage, EXP_BITS chained step units of six stages (8 modular
// multipliers per matrix product), one output stage.
// arst_n clears the valid bits only; data registers hold no reset.
// The receiver cannot stall, so the pipeline always advances.
module matrix2x2_modular_power
	import m2mp_pkg::*;
#(
	parameter int unsigned EXP_BITS = 60
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  entry_t              entry_00,
	input  entry_t              entry_01,
	input  entry_t              entry_10,
	input  entry_t              entry_11,
	input  logic [EXP_BITS-1:0] exponent,
	output logic                done,
	output entry_t              result_00,
	output entry_t              result_01,
	output entry_t              result_10,
	output entry_t              result_11
);

	assign busy = 1'b0;

	mat_t             base_c [EXP_BITS+1];
	mat_t             acc_c  [EXP_BITS+1];
	logic [EXP_BITS-1:0] exp_c [EXP_BITS+1];

	mat_t                base_s1;
	logic [EXP_BITS-1:0] exp_s1;

	// valid bits travel alongside the data
	logic [EXP_BITS*MUL_LAT+1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[EXP_BITS*MUL_LAT:0], start & ~busy};
		end
	end

	// input reduce stage
	always_ff @(posedge clk) begin
		base_s1 <= '{m00: fold_once({1'b0, entry_00}), m01: fold_once({1'b0, entry_01}),
			m10: fold_once({1'b0, entry_10}), m11: fold_once({1'b0, entry_11})};
		exp_s1  <= exponent;
	end

	assign base_c[0] = base_s1;
	assign acc_c[0]  = MAT_IDENT;
	assign exp_c[0]  = exp_s1;

	for (genvar s = 0; s < EXP_BITS; s++) begin : g_step
		m2mp_step #(.EXP_W(EXP_BITS)) u_step (
			.clk(clk), .en(1'b1),
			.base_in(base_c[s]), .acc_in(acc_c[s]), .exp_in(exp_c[s]),
			.base_out(base_c[s+1]), .acc_out(acc_c[s+1]),
			.exp_out(exp_c[s+1])
		);
	end

	// output stage
	always_ff @(posedge clk) begin
		result_00 <= acc_c[EXP_BITS].m00;
		result_01 <= acc_c[EXP_BITS].m01;
		result_10 <= acc_c[EXP_BITS].m10;
		result_11 <= acc_c[EXP_BITS].m11;
	end

	assign done = vld_q[EXP_BITS*MUL_LAT+1];

endmodule

// ----- sv/m2mp_modmul.sv -----
// Modular multiply of one entry pair, a*b mod PRIME, four register stages.
// s1: 30x30 product. s2: high half times a 31-bit reciprocal, quotient estimate.
// s3: quotient times prime, subtract on the low 32 bits.
// s4: final correction (remainder < 4*PRIME before it).
module m2mp_modmul
	import m2mp_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  entry_t a,
	input  entry_t b,
	output entry_t r
);

	localparam logic [33:0] P1 = 34'(PRIME);
	localparam logic [33:0] P2 = P1 << 1;
	localparam logic [33:0] P3 = P1 + P2;

	logic [PROD_W-1:0] prod_s1;
	logic [31:0]       prod_s2;
	logic [30:0]       q_s2;
	logic [31:0]       rem_s3;
	logic [60:0]       qwide;
	logic [31:0]       qp;
	logic [33:0]       d1, d2, d3;
	logic [33:0]       rem_fix;

	// estimate < 2^31 and short of the true quotient by at most three
	assign qwide = 61'(prod_s1[59:30]) * 61'(RECIP);
	// remainder fits in 32 bits, so only the low 32 bits of q*PRIME matter
	assign qp    = 32'(q_s2) * 32'(PRIME);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(a) * PROD_W'(b);
			prod_s2 <= prod_s1[31:0];
			q_s2    <= qwide[60:30];
			rem_s3  <= prod_s2 - qp;
		end
	end

	// take off up to three multiples, all compares side by side
	always_comb begin
		d1 = {2'b00, rem_s3} - P1;
		d2 = {2'b00, rem_s3} - P2;
		d3 = {2'b00, rem_s3} - P3;
		if (!d3[33]) begin
			rem_fix = d3;
		end else if (!d2[33]) begin
			rem_fix = d2;
		end else if (!d1[33]) begin
			rem_fix = d1;
		end else begin
			rem_fix = {2'b00, rem_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r <= rem_fix[ENTRY_W-1:0];
		end
	end

endmodule

// ----- sv/m2mp_matmul.sv -----
// 2x2 matrix product mod PRIME: eight modular multiplies, then pair sums folded.
module m2mp_matmul
	import m2mp_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  mat_t x,
	input  mat_t y,
	output mat_t z
);

	entry_t p [8];
	entry_t xa [8];
	entry_t yb [8];

	always_comb begin
		xa[0] = x.m00; yb[0] = y.m00;
		xa[1] = x.m01; yb[1] = y.m10;
		xa[2] = x.m00; yb[2] = y.m01;
		xa[3] = x.m01; yb[3] = y.m11;
		xa[4] = x.m10; yb[4] = y.m00;
		xa[5] = x.m11; yb[5] = y.m10;
		xa[6] = x.m10; yb[6] = y.m01;
		xa[7] = x.m11; yb[7] = y.m11;
	end

	for (genvar g = 0; g < 8; g++) begin : g_mul
		m2mp_modmul u_mul (.clk(clk), .en(en), .a(xa[g]), .b(yb[g]), .r(p[g]));
	end

	// sum stage then fold stage
	logic [ENTRY_W:0] sum_s5 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sum_s5[i] <= {1'b0, p[2*i]} + {1'b0, p[2*i+1]};
			end
			z.m00 <= fold_once(sum_s5[0]);
			z.m01 <= fold_once(sum_s5[1]);
			z.m10 <= fold_once(sum_s5[2]);
			z.m11 <= fold_once(sum_s5[3]);
		end
	end

endmodule

// ----- sv/m2mp_step.sv -----
// One exponent bit: square the base, and multiply the running power by the base
// where the bit is set. Both products run side by side.
module m2mp_step
	import m2mp_pkg::*;
#(
	parameter int unsigned EXP_W = 60
) (
	input  logic             clk,
	input  logic             en,
	input  mat_t             base_in,
	input  mat_t             acc_in,
	input  logic [EXP_W-1:0] exp_in,
	output mat_t             base_out,
	output mat_t             acc_out,
	output logic [EXP_W-1:0] exp_out
);

	mat_t sq, pr;
	logic             use_d [MUL_LAT];
	mat_t             acc_d [MUL_LAT];
	logic [EXP_W-1:0] exp_d [MUL_LAT];

	m2mp_matmul u_sq (.clk(clk), .en(en), .x(base_in), .y(base_in), .z(sq));
	m2mp_matmul u_pr (.clk(clk), .en(en), .x(acc_in),  .y(base_in), .z(pr));

	// side band delay line matching the multiplier
	always_ff @(posedge clk) begin
		if (en) begin
			use_d[0] <= exp_in[0];
			acc_d[0] <= acc_in;
			exp_d[0] <= exp_in >> 1;
			for (int i = 1; i < MUL_LAT; i++) begin
				use_d[i] <= use_d[i-1];
				acc_d[i] <= acc_d[i-1];
				exp_d[i] <= exp_d[i-1];
			end
		end
	end

	assign base_out = sq;
	assign acc_out  = use_d[MUL_LAT-1] ? pr : acc_d[MUL_LAT-1];
	assign exp_out  = exp_d[MUL_LAT-1];

endmodule

// ----- dv/m2mp_checker.sv -----
`timescale 1ns / 1ps

// Watches the request and result channels of the matrix power block, predicts
// each result and compares it with the one that comes out.
module m2mp_checker
	import m2mp_pkg::*;
#(
	parameter int unsigned EXP_BITS = 60
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  entry_t              entry_00,
	input  entry_t              entry_01,
	input  entry_t              entry_10,
	input  entry_t              entry_11,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic                done,
	input  entry_t              result_00,
	input  entry_t              result_01,
	input  entry_t              result_10,
	input  entry_t              result_11,
	output int                  fail_count,
	output int                  pending
);

	localparam longint unsigned MODULUS = 64'd1000000007;

	mat_t expected_powers[$];

	// modular 2x2 product; all operands are below the modulus
	function automatic mat_t mod_mat_mul(mat_t x, mat_t y);
		longint unsigned a00, a01, a10, a11, b00, b01, b10, b11;
		mat_t r;
		a00 = x.m00; a01 = x.m01; a10 = x.m10; a11 = x.m11;
		b00 = y.m00; b01 = y.m01; b10 = y.m10; b11 = y.m11;
		r.m00 = entry_t'(((a00 * b00) % MODULUS + a01 * b10) % MODULUS);
		r.m01 = entry_t'(((a00 * b01) % MODULUS + a01 * b11) % MODULUS);
		r.m10 = entry_t'(((a10 * b00) % MODULUS + a11 * b10) % MODULUS);
		r.m11 = entry_t'(((a10 * b01) % MODULUS + a11 * b11) % MODULUS);
		return r;
	endfunction

	function automatic entry_t reduce_once(entry_t v);
		return (64'(v) >= MODULUS) ? entry_t'(64'(v) - MODULUS) : v;
	endfunction

	// square-and-multiply from the low exponent bit upwards
	function automatic mat_t mat_power(mat_t m, logic [EXP_BITS-1:0] e);
		mat_t b, acc;
		b.m00 = reduce_once(m.m00);
		b.m01 = reduce_once(m.m01);
		b.m10 = reduce_once(m.m10);
		b.m11 = reduce_once(m.m11);
		acc = '{m00: 30'd1, m01: 30'd0, m10: 30'd0, m11: 30'd1};
		for (int i = 0; i < EXP_BITS; i++) begin
			if (e[i])
				acc = mod_mat_mul(acc, b);
			b = mod_mat_mul(b, b);
		end
		return acc;
	endfunction

	assign pending = expected_powers.size();

	always @(posedge clk or negedge arst_n) begin
		mat_t got, want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				expected_powers.push_back(mat_power('{entry_00, entry_01, entry_10, entry_11},
					exponent));
			if (done) begin
				got = '{result_00, result_01, result_10, result_11};
				if (expected_powers.size() == 0) begin
					$display("%0t: unexpected result %h expected none", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_powers.pop_front();
					if (got.m00 !== want.m00 || got.m01 !== want.m01 ||
						got.m10 !== want.m10 || got.m11 !== want.m11) begin
						$display("%0t: result mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
							$time, want.m00, want.m01, want.m10, want.m11,
							got.m00, got.m01, got.m10, got.m11);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import m2mp_pkg::*;

	localparam int unsigned EXP_BITS = 60;
	localparam int unsigned LATENCY  = 6 * EXP_BITS + 2;
	localparam int unsigned WATCHDOG = 20000;
	localparam int unsigned N_RANDOM = 1100;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	entry_t              entry_00 = '0, entry_01 = '0, entry_10 = '0, entry_11 = '0;
	logic [EXP_BITS-1:0] exponent = '0;
	logic                done;
	entry_t              result_00, result_01, result_10, result_11;
	int                  fail_count;
	int                  pending;
	int                  idle_cycles;

	always #2 clk = ~clk;

	matrix2x2_modular_power #(.EXP_BITS(EXP_BITS)) uut (.*);

	m2mp_checker #(.EXP_BITS(EXP_BITS)) checker_i (.*);

	// watchdog on cycles with nothing accepted and no result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic entry_t rand_entry();
		case ($urandom_range(0, 5))
			0: return entry_t'($urandom_range(0, 3));
			1: return entry_t'(1000000006 - $urandom_range(0, 3));
			2: return entry_t'($urandom_range(1000000007, 30'h3fffffff));
			default: return entry_t'($urandom);
		endcase
	endfunction

	function automatic logic [EXP_BITS-1:0] rand_exponent();
		case ($urandom_range(0, 4))
			0: return EXP_BITS'($urandom_range(0, 20));
			1: return {EXP_BITS{1'b1}} >> $urandom_range(0, EXP_BITS - 1);
			default: return EXP_BITS'({$urandom, $urandom});
		endcase
	endfunction

	// one request beat, then a random gap, mostly short
	task automatic send_beat(entry_t a, entry_t b, entry_t c, entry_t d,
		logic [EXP_BITS-1:0] e);
		int gap;
		start    <= 1'b1;
		entry_00 <= a;
		entry_01 <= b;
		entry_10 <= c;
		entry_11 <= d;
		exponent <= e;
		do @(posedge clk); while (busy);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
			($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	localparam entry_t TOP = 30'd1000000006;
	localparam entry_t ALL = 30'h3fffffff;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero exponent, identity, extremes, unreduced entries
		send_beat(5, 6, 7, 8, '0);
		send_beat(ALL, ALL, ALL, ALL, '0);
		send_beat(1, 0, 0, 1, {EXP_BITS{1'b1}});
		send_beat(0, 0, 0, 0, 1);
		send_beat(0, 0, 0, 0, {EXP_BITS{1'b1}});
		send_beat(1, 1, 1, 0, 1);
		send_beat(1, 1, 1, 0, 2);
		send_beat(1, 1, 1, 0, 90);
		send_beat(TOP, TOP, TOP, TOP, 1);
		send_beat(TOP, TOP, TOP, TOP, {EXP_BITS{1'b1}});
		send_beat(ALL, ALL, ALL, ALL, 1);
		send_beat(ALL, 30'd1000000007, 30'd1000000008, ALL, 3);
		send_beat(2, 3, 5, 7, {1'b1, {(EXP_BITS - 1){1'b0}}});
		send_beat(TOP, 1, 0, TOP, 1000000006);
		send_beat(123456789, 987654321, 55555555, 999999999, 60'h5555_5555_5555_555);
		send_beat(ALL, 0, ALL, 0, 60'haaaa_aaaa_aaaa_aaa);
		send_beat(30'h2aaaaaaa, 30'h15555555, 30'h2aaaaaaa, 30'h15555555, 7);

		// hold off until the pipeline has emptied
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			send_beat(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
				rand_exponent());
			if (i == N_RANDOM / 2)
				drain();
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
sv/m2mp_pkg.sv
sv/m2mp_modmul.sv
sv/m2mp_matmul.sv
sv/m2mp_step.sv
sv/matrix2x2_modular_power.sv
dv/m2mp_checker.sv
dv/tb.sv
